// File: sv/bcmp_pkg.sv
`default_nettype none
package bcmp_pkg;

    localparam int RAW_W  = 24;
    localparam int OUT_W  = 24;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // widths of the polynomial terms, all signed
    localparam int N_W  = 61;    // t_lin * 2^48
    localparam int A3_W = 34;
    localparam int A2_W = 87;
    localparam int A1_W = 148;
    localparam int A0_W = 205;
    localparam int B2_W = 96;
    localparam int B1_W = 158;
    localparam int S_W  = 220;   // pressure numerator over 2^181

    localparam int PQ_LSB = 175;
    localparam int PQ_TOP = PQ_LSB + OUT_W;

    localparam logic signed [16:0] P_OFFSET = 17'sd16384;

    typedef enum logic [1:0] {
        REG_TEMP    = 2'd0,
        REG_PRESS_A = 2'd1,
        REG_PRESS_B = 2'd2,
        REG_PRESS_C = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1;
        logic signed [16:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } calib_t;

    typedef struct packed {
        logic signed [N_W-1:0]  n;
        logic signed [A1_W-1:0] a1;
        logic signed [A0_W-1:0] a0;
        logic signed [OUT_W-1:0] tq;
    } side1_t;

    typedef struct packed {
        logic signed [N_W-1:0]  n;
        logic signed [A0_W-1:0] a0;
        logic signed [OUT_W-1:0] tq;
    } side2_t;

endpackage
`default_nettype wire

// File: sv/bcmp_if.sv
`default_nettype none
interface bcmp_in_if;
    import bcmp_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bcmp_out_if;
    import bcmp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] temperature_q16;
    logic        [OUT_W-1:0] pressure_q6;

    modport source (output valid, output temperature_q16, output pressure_q6, input ready);
    modport sink   (input valid, input temperature_q16, input pressure_q6, output ready);
endinterface
`default_nettype wire

// File: sv/bcmp_regs.sv
`default_nettype none
module bcmp_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [bcmp_pkg::DATA_W-1:0]  pwdata,
    output logic [bcmp_pkg::DATA_W-1:0]  prdata,
    output bcmp_pkg::calib_t             calib
);
    import bcmp_pkg::*;

    logic [39:0] temp_calib_reg,    temp_calib_next;
    logic [47:0] press_calib_a_reg, press_calib_a_next;
    logic [63:0] press_calib_b_reg, press_calib_b_next;
    logic [15:0] press_calib_c_reg, press_calib_c_next;
    reg_idx_t    idx;
    logic        wr;

    assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr  = psel & penable & pwrite;

    always_comb
    begin
        temp_calib_next    = temp_calib_reg;
        press_calib_a_next = press_calib_a_reg;
        press_calib_b_next = press_calib_b_reg;
        press_calib_c_next = press_calib_c_reg;
        if (wr)
        begin
            unique case (idx)
                REG_TEMP:    temp_calib_next    = pwdata[39:0];
                REG_PRESS_A: press_calib_a_next = pwdata[47:0];
                REG_PRESS_B: press_calib_b_next = pwdata;
                REG_PRESS_C: press_calib_c_next = pwdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg    <= '0;
            press_calib_a_reg <= '0;
            press_calib_b_reg <= '0;
            press_calib_c_reg <= '0;
        end
        else
        begin
            temp_calib_reg    <= temp_calib_next;
            press_calib_a_reg <= press_calib_a_next;
            press_calib_b_reg <= press_calib_b_next;
            press_calib_c_reg <= press_calib_c_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TEMP:    prdata = DATA_W'(temp_calib_reg);
            REG_PRESS_A: prdata = DATA_W'(press_calib_a_reg);
            REG_PRESS_B: prdata = press_calib_b_reg;
            REG_PRESS_C: prdata = DATA_W'(press_calib_c_reg);
        endcase
    end

    always_comb
    begin
        calib.t1  = temp_calib_reg[15:0];
        calib.t2  = temp_calib_reg[31:16];
        calib.t3  = $signed(temp_calib_reg[39:32]);
        calib.p1  = $signed({1'b0, press_calib_a_reg[15:0]}) - P_OFFSET;
        calib.p2  = $signed({1'b0, press_calib_a_reg[31:16]}) - P_OFFSET;
        calib.p3  = $signed(press_calib_a_reg[39:32]);
        calib.p4  = $signed(press_calib_a_reg[47:40]);
        calib.p5  = press_calib_b_reg[15:0];
        calib.p6  = press_calib_b_reg[31:16];
        calib.p7  = $signed(press_calib_b_reg[39:32]);
        calib.p8  = $signed(press_calib_b_reg[47:40]);
        calib.p9  = $signed(press_calib_b_reg[63:48]);
        calib.p10 = $signed(press_calib_c_reg[7:0]);
        calib.p11 = $signed(press_calib_c_reg[15:8]);
    end

endmodule
`default_nettype wire

// File: sv/bcmp_front.sv
`default_nettype none
module bcmp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [bcmp_pkg::RAW_W-1:0]          raw_pressure,
    input  logic [bcmp_pkg::RAW_W-1:0]          raw_temperature,
    input  bcmp_pkg::calib_t                    calib,
    output logic                                out_valid,
    output logic signed [bcmp_pkg::N_W-1:0]     n,
    output logic signed [bcmp_pkg::OUT_W-1:0]   tq,
    output logic signed [bcmp_pkg::A3_W-1:0]    a3,
    output logic signed [bcmp_pkg::A2_W-1:0]    a2,
    output logic signed [bcmp_pkg::A1_W-1:0]    a1,
    output logic signed [bcmp_pkg::A0_W-1:0]    a0
);
    import bcmp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1
    logic signed [25:0] d1_reg;
    logic [RAW_W-1:0]   q1_reg;
    // stage 2
    logic signed [42:0] dt2_reg;
    logic signed [51:0] dd_reg;
    logic [47:0]        q2_reg;
    logic [RAW_W-1:0]   qq_reg;
    logic signed [32:0] p3q_reg, p4q_reg;
    logic signed [41:0] p1q_reg, p2q_reg;
    // stage 3
    logic signed [59:0]     ddt3;
    logic signed [N_W-1:0]  n3_reg;
    logic [71:0]            q3_reg;
    logic signed [64:0]     p9q2_reg;
    logic signed [56:0]     p10q2_reg;
    logic signed [A3_W-1:0] a3_3_reg;
    logic signed [A2_W-1:0] a2_3_reg;
    logic signed [41:0]     p1q3_reg, p2q3_reg;
    // stage 4
    logic signed [28:0]      nh;
    logic signed [OUT_W-1:0] tq_sat;
    logic signed [N_W-1:0]   n4_reg;
    logic signed [OUT_W-1:0] tq4_reg;
    logic signed [A3_W-1:0]  a3_4_reg;
    logic signed [A2_W-1:0]  a2_4_reg;
    logic signed [A1_W-1:0]  a1_4_reg;
    logic signed [A0_W-1:0]  a0a_reg;
    logic signed [64:0]      p9q2_4_reg;
    logic signed [80:0]      p11q3_reg;
    // stage 5
    logic signed [N_W-1:0]   n5_reg;
    logic signed [OUT_W-1:0] tq5_reg;
    logic signed [A3_W-1:0]  a3_5_reg;
    logic signed [A2_W-1:0]  a2_5_reg;
    logic signed [A1_W-1:0]  a1_5_reg;
    logic signed [A0_W-1:0]  a0_reg;

    assign ddt3 = dd_reg * $signed(calib.t3);

    // floor(t_lin * 2^16), saturated to 24 bits
    assign nh = n3_reg[N_W-1:32];
    always_comb
    begin
        if ((&nh[28:23]) || !(|nh[28:23]))
            tq_sat = nh[OUT_W-1:0];
        else if (nh[28])
            tq_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            tq_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= $signed({2'b00, raw_temperature}) - $signed({2'b00, calib.t1, 8'h00});
            q1_reg <= raw_pressure;

            dt2_reg <= d1_reg * $signed({1'b0, calib.t2});
            dd_reg  <= d1_reg * d1_reg;
            q2_reg  <= q1_reg * q1_reg;
            qq_reg  <= q1_reg;
            p3q_reg <= $signed(calib.p3) * $signed({1'b0, q1_reg});
            p4q_reg <= $signed(calib.p4) * $signed({1'b0, q1_reg});
            p1q_reg <= $signed(calib.p1) * $signed({1'b0, q1_reg});
            p2q_reg <= $signed(calib.p2) * $signed({1'b0, q1_reg});

            n3_reg    <= (N_W'(dt2_reg) <<< 18) + N_W'(ddt3);
            q3_reg    <= q2_reg * qq_reg;
            p9q2_reg  <= $signed(calib.p9) * $signed({1'b0, q2_reg});
            p10q2_reg <= $signed(calib.p10) * $signed({1'b0, q2_reg});
            a3_3_reg  <= (A3_W'($signed(calib.p8)) <<< 22) + A3_W'(p4q_reg);
            a2_3_reg  <= (A2_W'($signed(calib.p7)) <<< 77) + (A2_W'(p3q_reg) <<< 53);
            p1q3_reg  <= p1q_reg;
            p2q3_reg  <= p2q_reg;

            n4_reg     <= n3_reg;
            tq4_reg    <= tq_sat;
            a3_4_reg   <= a3_3_reg;
            a2_4_reg   <= a2_3_reg;
            a1_4_reg   <= (A1_W'($signed({1'b0, calib.p6})) <<< 127)
                        + (A1_W'(p2q3_reg) <<< 104)
                        + (A1_W'(p10q2_reg) <<< 85);
            a0a_reg    <= (A0_W'($signed({1'b0, calib.p5})) <<< 184)
                        + (A0_W'(p1q3_reg) <<< 161);
            p9q2_4_reg <= p9q2_reg;
            p11q3_reg  <= $signed(calib.p11) * $signed({1'b0, q3_reg});

            n5_reg   <= n4_reg;
            tq5_reg  <= tq4_reg;
            a3_5_reg <= a3_4_reg;
            a2_5_reg <= a2_4_reg;
            a1_5_reg <= a1_4_reg;
            a0_reg   <= a0a_reg + (A0_W'(p9q2_4_reg) <<< 133) + (A0_W'(p11q3_reg) <<< 116);
        end
    end

    assign out_valid = v5_reg;
    assign n         = n5_reg;
    assign tq        = tq5_reg;
    assign a3        = a3_5_reg;
    assign a2        = a2_5_reg;
    assign a1        = a1_5_reg;
    assign a0        = a0_reg;

endmodule
`default_nettype wire

// File: sv/bcmp_mul.sv
`default_nettype none
// y = a * b + c, pipelined: magnitude, 32x32 partial products, registered
// adder tree, sign, then the addend. Side data rides along unchanged.
module bcmp_mul #(
    parameter int WA = 34,
    parameter int WB = 61,
    parameter int WC = 87,
    parameter int WY = 96,
    parameter int WS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [WA-1:0] a,
    input  logic signed [WB-1:0] b,
    input  logic signed [WC-1:0] c,
    input  logic [WS-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [WY-1:0] y,
    output logic [WS-1:0]        side_out
);
    localparam int WP  = WA + WB;
    localparam int NA  = (WA + 31) / 32;
    localparam int NB  = (WB + 31) / 32;
    localparam int MAW = NA * 32;
    localparam int MBW = NB * 32;
    localparam int WW  = MAW + MBW;
    localparam int NPP = NA * NB;
    localparam int LV  = (NPP > 1) ? $clog2(NPP) : 0;
    localparam int LAT = LV + 4;

    logic                 vld_reg  [0:LAT-1];
    logic [WS-1:0]        side_reg [0:LAT-1];
    logic                 neg_reg  [0:LAT-3];
    logic signed [WC-1:0] c_reg    [0:LAT-2];
    logic [MAW-1:0]       ma_reg;
    logic [MBW-1:0]       mb_reg;
    logic [WP-1:0]        tr_reg   [0:LV][0:NPP-1];
    logic signed [WP-1:0] prod_reg;
    logic signed [WY-1:0] y_reg;

    logic [WA-1:0] a_mag;
    logic [WB-1:0] b_mag;
    logic [63:0]   pp [0:NPP-1];

    assign a_mag = a[WA-1] ? WA'(-a) : WA'(a);
    assign b_mag = b[WB-1] ? WB'(-b) : WB'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp[i*NB + j] = ma_reg[32*i +: 32] * mb_reg[32*j +: 32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            neg_reg[0] <= a[WA-1] ^ b[WB-1];
            for (int s = 1; s < LAT - 2; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
            end
            c_reg[0] <= c;
            for (int s = 1; s < LAT - 1; s++)
            begin
                c_reg[s] <= c_reg[s-1];
            end

            ma_reg <= MAW'(a_mag);
            mb_reg <= MBW'(b_mag);

            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    tr_reg[0][i*NB + j] <= WP'(WW'(pp[i*NB + j]) << (32 * (i + j)));
                end
            end

            for (int l = 1; l <= LV; l++)
            begin
                for (int k = 0; k < NPP; k++)
                begin
                    if (2*k + 1 < NPP)
                        tr_reg[l][k] <= tr_reg[l-1][2*k] + tr_reg[l-1][2*k + 1];
                    else if (2*k < NPP)
                        tr_reg[l][k] <= tr_reg[l-1][2*k];
                    else
                        tr_reg[l][k] <= '0;
                end
            end

            prod_reg <= neg_reg[LV+1] ? -$signed(tr_reg[LV][0]) : $signed(tr_reg[LV][0]);
            y_reg    <= WY'(prod_reg) + WY'(c_reg[LAT-2]);
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign side_out  = side_reg[LAT-1];
    assign y         = y_reg;

endmodule
`default_nettype wire

// File: sv/barometer_compensation.sv
`default_nettype none
// Barometer compensation.
// in_ch carries one word per sample: raw_pressure and raw_temperature, 24 bits
// each. out_ch returns one word per sample: temperature_q16 (signed, 1/65536
// degC) and pressure_q6 (1/64 Pa), both floored and saturated.
// Calibration lives in four registers on the APB port, 8 bytes apart:
// temp_calib, press_calib_a, press_calib_b, press_calib_c. Write them while
// no sample is in flight. pready is tied high.
// Throughput: one sample per cycle while out_ch is not stalled. A sample passes
// from acceptance to out_ch.valid through the front end (5 stages) and the three
// Horner multiply-add pipelines in t_lin (6, 7 and 8 stages), then the
// output register.
// When out_ch.ready is low with a word waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated. Reset clears all valid
// bits and the calibration registers to zero.
module barometer_compensation (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [bcmp_pkg::DATA_W-1:0]  pwdata,
    output logic [bcmp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    bcmp_in_if.sink                      in_ch,
    bcmp_out_if.source                   out_ch
);
    import bcmp_pkg::*;

    calib_t calib;
    logic   en;
    logic   out_valid_reg;
    logic signed [OUT_W-1:0] tq_out_reg;
    logic        [OUT_W-1:0] pq_out_reg;
    logic        [OUT_W-1:0] pq_sat;

    logic                    f_vld;
    logic signed [N_W-1:0]   f_n;
    logic signed [OUT_W-1:0] f_tq;
    logic signed [A3_W-1:0]  f_a3;
    logic signed [A2_W-1:0]  f_a2;
    logic signed [A1_W-1:0]  f_a1;
    logic signed [A0_W-1:0]  f_a0;

    side1_t sd1_in, sd1_out;
    side2_t sd2_in, sd2_out;
    logic                    m1_vld, m2_vld, m3_vld;
    logic signed [B2_W-1:0]  b2;
    logic signed [B1_W-1:0]  b1;
    logic signed [S_W-1:0]   s;
    logic [OUT_W-1:0]        s3_tq;

    assign en          = ~out_valid_reg | out_ch.ready;
    assign in_ch.ready = en;
    assign pready      = 1'b1;

    bcmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .calib   (calib)
    );

    bcmp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_ch.valid),
        .raw_pressure    (in_ch.raw_pressure),
        .raw_temperature (in_ch.raw_temperature),
        .calib           (calib),
        .out_valid       (f_vld),
        .n               (f_n),
        .tq              (f_tq),
        .a3              (f_a3),
        .a2              (f_a2),
        .a1              (f_a1),
        .a0              (f_a0)
    );

    // Horner in t_lin: ((a3*n + a2)*n + a1)*n + a0
    assign sd1_in = '{n: f_n, a1: f_a1, a0: f_a0, tq: f_tq};

    bcmp_mul #(
        .WA (A3_W), .WB (N_W), .WC (A2_W), .WY (B2_W), .WS ($bits(side1_t))
    ) u_mul1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_vld),
        .a         (f_a3),
        .b         (f_n),
        .c         (f_a2),
        .side_in   (sd1_in),
        .out_valid (m1_vld),
        .y         (b2),
        .side_out  (sd1_out)
    );

    assign sd2_in = '{n: sd1_out.n, a0: sd1_out.a0, tq: sd1_out.tq};

    bcmp_mul #(
        .WA (B2_W), .WB (N_W), .WC (A1_W), .WY (B1_W), .WS ($bits(side2_t))
    ) u_mul2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m1_vld),
        .a         (b2),
        .b         (sd1_out.n),
        .c         (sd1_out.a1),
        .side_in   (sd2_in),
        .out_valid (m2_vld),
        .y         (b1),
        .side_out  (sd2_out)
    );

    bcmp_mul #(
        .WA (B1_W), .WB (N_W), .WC (A0_W), .WY (S_W), .WS (OUT_W)
    ) u_mul3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m2_vld),
        .a         (b1),
        .b         (sd2_out.n),
        .c         (sd2_out.a0),
        .side_in   (sd2_out.tq),
        .out_valid (m3_vld),
        .y         (s),
        .side_out  (s3_tq)
    );

    // floor to 1/64 Pa: drop 175 fraction bits, clamp to [0, 2^24-1]
    always_comb
    begin
        if (s[S_W-1])
            pq_sat = '0;
        else if (|s[S_W-2:PQ_TOP])
            pq_sat = '1;
        else
            pq_sat = s[PQ_TOP-1:PQ_LSB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= m3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tq_out_reg <= $signed(s3_tq);
            pq_out_reg <= pq_sat;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.temperature_q16 = tq_out_reg;
    assign out_ch.pressure_q6     = pq_out_reg;

endmodule
`default_nettype wire

// File: sv/bcmp_checker.sv
`default_nettype none
module bcmp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [bcmp_pkg::OUT_W-1:0]  out_temp,
    input  logic [bcmp_pkg::OUT_W-1:0]  out_press
);
    // pipeline moves exactly when the output slot is free or being drained
    a_ready_follows_output: assert property (@(posedge clk)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track the output stall");

    a_reset_no_word: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result word shown during reset");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_temp) && $stable(out_press))
        else $error("result word changed while stalled");

    a_in_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(in_valid))
        else $error("input valid unknown out of reset");

endmodule

bind barometer_compensation bcmp_checker u_bcmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_temp  (out_ch.temperature_q16),
    .out_press (out_ch.pressure_q6)
);
`default_nettype wire
